// ----- hdl/wpj_pkg.sv -----
package wpj_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;

	localparam int QW    = 21;
	localparam int DW    = 64;
	localparam int RW    = 24;
	localparam int NPRE  = 5;
	localparam int NST   = NPRE + QW + 1;

	localparam logic signed [RW-1:0] HALF_X  = RW'(SCREEN_WIDTH * 8);
	localparam logic signed [RW-1:0] HALF_Y  = RW'(SCREEN_HEIGHT * 8);
	localparam logic signed [RW-1:0] OUT_MAX = RW'(524287);
	localparam logic signed [RW-1:0] OUT_MIN = -RW'(524288);

	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] CFG_FORWARD  = 3'd3;
	localparam logic [2:0] CFG_RIGHT    = 3'd4;
	localparam logic [2:0] CFG_UP       = 3'd5;
	localparam logic [2:0] CFG_FOCAL_X  = 3'd6;
	localparam logic [2:0] CFG_FOCAL_Y  = 3'd7;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [DW-1:0] dsh;
		logic [QW-1:0] quo;
		logic          neg;
		logic          sat;
	} div_lane_t;

endpackage

// ----- hdl/wpj_in_if.sv -----
interface wpj_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

// ----- hdl/wpj_out_if.sv -----
interface wpj_out_if;
	logic               valid;
	logic               ready;
	logic               in_front;
	logic signed [19:0] screen_x;
	logic signed [19:0] screen_y;
	modport source(output valid, in_front, screen_x, screen_y, input ready);
	modport sink(input valid, in_front, screen_x, screen_y, output ready);
endinterface

// ----- hdl/world_to_screen_projection.sv -----
// Throughput: one point per cycle; a stall only backs up as far as empty stages allow.
// Stages: subtract, 9 multiplies, sum/floor, focal multiply, magnitude, 21 divider cells, output.
// Reset: arst_n clears all valid bits and loads the camera registers with their
// default pose (forward x, right y, up z, focal 320.0).
module world_to_screen_projection (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	wpj_in_if.sink      pnt,
	wpj_out_if.source   res
);
	import wpj_pkg::*;

	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic [47:0]        forward_q, right_q, up_q;
	logic [23:0]        focal_x_q, focal_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			forward_q  <= 48'd16384;
			right_q    <= 48'd1073741824;
			up_q       <= 48'd70368744177664;
			focal_x_q  <= 24'd81920;
			focal_y_q  <= 24'd81920;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= cfg_data[31:0];
				CFG_ORIGIN_Y: origin_y_q <= cfg_data[31:0];
				CFG_ORIGIN_Z: origin_z_q <= cfg_data[31:0];
				CFG_FORWARD:  forward_q  <= cfg_data;
				CFG_RIGHT:    right_q    <= cfg_data;
				CFG_UP:       up_q       <= cfg_data;
				CFG_FOCAL_X:  focal_x_q  <= cfg_data[23:0];
				CFG_FOCAL_Y:  focal_y_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !v_q[NST-1] || res.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= pnt.valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign pnt.ready = en[0];

	// s1: offset from camera
	logic signed [32:0] t_s1 [3];
	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1[0] <= 33'(pnt.point_x) - 33'(origin_x_q);
			t_s1[1] <= 33'(pnt.point_y) - 33'(origin_y_q);
			t_s1[2] <= 33'(pnt.point_z) - 33'(origin_z_q);
		end
	end

	// s2: component products, lane 0 depth, 1 right, 2 up
	logic signed [48:0] p_s2 [3][3];
	logic [47:0] axis [3];
	assign axis[0] = forward_q;
	assign axis[1] = right_q;
	assign axis[2] = up_q;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int l = 0; l < 3; l++) begin
				for (int i = 0; i < 3; i++) begin
					p_s2[l][i] <= 49'(t_s1[i]) * 49'($signed(axis[l][16*i +: 16]));
				end
			end
		end
	end

	// s3: sum and floor to Q.8
	logic signed [50:0] sum [3];
	logic signed [36:0] d_s3 [3];
	logic               front_s3;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sum[l] = 51'(p_s2[l][0]) + 51'(p_s2[l][1]) + 51'(p_s2[l][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int l = 0; l < 3; l++) d_s3[l] <= sum[l][50:14];
			front_s3 <= $signed(sum[0][50:14]) > 37'sd1;
		end
	end

	// s4: numerators and denominator
	logic signed [61:0] num_s4 [2];
	logic [40:0]        den_s4;
	logic               front_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_s4[0] <= 62'(d_s3[1]) * 62'($signed({1'b0, focal_x_q}));
			num_s4[1] <= 62'(d_s3[2]) * 62'($signed({1'b0, focal_y_q}));
			den_s4    <= {d_s3[0][36:0], 4'b0};
			front_s4  <= front_s3;
		end
	end

	// s5: magnitude and quotient overflow
	div_lane_t          c_in [2];
	logic               front_s5;
	logic [DW-1:0]      den64;
	logic [DW-1:0]      mag [2];
	assign den64 = DW'(den_s4);

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag[l] = num_s4[l][61] ? DW'(-64'(num_s4[l])) : DW'(64'(num_s4[l]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int l = 0; l < 2; l++) begin
				c_in[l].rem <= mag[l];
				c_in[l].dsh <= den64 << (QW - 1);
				c_in[l].quo <= '0;
				c_in[l].neg <= num_s4[l][61];
				c_in[l].sat <= mag[l] >= (den64 << QW);
			end
			front_s5 <= front_s4;
		end
	end

	// divider cell row, one quotient bit per cell
	div_lane_t chain [2][QW+1];
	logic      front_c_q [QW+1];
	assign chain[0][0] = c_in[0];
	assign chain[1][0] = c_in[1];
	assign front_c_q[0] = front_s5;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		wpj_div_cell u_cx (.clk(clk), .en(en[NPRE+k]), .d(chain[0][k]), .q(chain[0][k+1]));
		wpj_div_cell u_cy (.clk(clk), .en(en[NPRE+k]), .d(chain[1][k]), .q(chain[1][k+1]));
		always_ff @(posedge clk) begin
			if (en[NPRE+k]) front_c_q[k+1] <= front_c_q[k];
		end
	end

	// output stage
	logic signed [RW-1:0] half [2];
	logic signed [RW-1:0] qs [2];
	logic signed [RW-1:0] r [2];
	logic signed [19:0]   scr [2];
	assign half[0] = HALF_X;
	assign half[1] = HALF_Y;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qs[l] = chain[l][QW].neg ? -RW'(chain[l][QW].quo) : RW'(chain[l][QW].quo);
			r[l]  = half[l] - qs[l];
			if (chain[l][QW].sat) begin
				scr[l] = chain[l][QW].neg ? OUT_MAX[19:0] : OUT_MIN[19:0];
			end else if (r[l] > OUT_MAX) begin
				scr[l] = OUT_MAX[19:0];
			end else if (r[l] < OUT_MIN) begin
				scr[l] = OUT_MIN[19:0];
			end else begin
				scr[l] = r[l][19:0];
			end
		end
	end

	logic               front_out;
	logic signed [19:0] sx_out, sy_out;
	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			front_out <= front_c_q[QW];
			sx_out    <= front_c_q[QW] ? scr[0] : '0;
			sy_out    <= front_c_q[QW] ? scr[1] : '0;
		end
	end

	assign res.valid    = v_q[NST-1];
	assign res.in_front = front_out;
	assign res.screen_x = sx_out;
	assign res.screen_y = sy_out;

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.in_front |-> res.screen_x == 20'sd0 && res.screen_y == 20'sd0)
		else $error("hidden point with nonzero screen position");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pnt.valid && pnt.ready |=> v_q[0])
		else $error("accepted beat lost at first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.screen_x) && $stable(res.screen_y))
		else $error("stalled result dropped");
endmodule

// ----- hdl/wpj_div_cell.sv -----
module wpj_div_cell (
	input  logic               clk,
	input  logic               en,
	input  wpj_pkg::div_lane_t d,
	output wpj_pkg::div_lane_t q
);
	import wpj_pkg::*;

	logic          take;
	logic [DW-1:0] diff;

	assign take = d.rem >= d.dsh;
	assign diff = d.rem - d.dsh;

	always_ff @(posedge clk) begin
		if (en) begin
			q.rem <= take ? diff : d.rem;
			q.dsh <= d.dsh >> 1;
			q.quo <= {d.quo[QW-2:0], take};
			q.neg <= d.neg;
			q.sat <= d.sat;
		end
	end
endmodule
